@@ hw/rtl/audio_frame_drop_policy_macros.svh @@
// Assertion macros shared by the frame drop policy RTL.
// Included by every module that carries concurrent assertions.
`ifndef AUDIO_FRAME_DROP_POLICY_MACROS_SVH
`define AUDIO_FRAME_DROP_POLICY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/afdp_pkg.sv @@
// Shared types and constants for the audio frame drop policy block.
// No dependencies; used by every module of the block.
`default_nettype none

package afdp_pkg;

    // Field widths fixed by the interface.
    localparam int QB_W       = 24;
    localparam int TAG_W      = 32;
    localparam int LEN_W      = 13;
    localparam int FQ_W       = 16;
    localparam int CH_W       = 4;
    localparam int LIM_W      = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = QB_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Drop kinds reported with each result.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HARD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOFT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT     = 3'd4;

    // Classified frame as it waits in the queue.
    typedef struct packed {
        logic [QB_W-1:0]  excess;
        logic [CH_W-1:0]  chan;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
    } frame_entry_t;

    // Queue status seen by front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE
    } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/audio_frame_drop_policy.sv @@
// Audio frame drop policy: each input beat passes the front end's holding stage and
// the queue, then the back end fetches it, runs its 24-step one-bit-per-cycle divider
// and decides; the back end takes no new frame until its result beat has been loaded.
// The front end and a two-entry queue keep taking input beats while the back works, until both are full.
// Reset is asynchronous: control, policy and configuration registers return to their
// defaults, drop counts and the period counter clear, and no clearing pass follows.
`default_nettype none

module audio_frame_drop_policy
#(
    parameter int FRAME_SAMPLES = 240,
    parameter int DROP_PERIOD   = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [afdp_pkg::QB_W-1:0]         queued_bytes,
    input  wire logic [afdp_pkg::TAG_W-1:0]        frame_tag,
    input  wire logic [afdp_pkg::LEN_W-1:0]        frame_length,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   forward,
    output logic [afdp_pkg::KIND_W-1:0]            drop_kind,
    output logic [afdp_pkg::TAG_W-1:0]             out_tag,
    output logic [afdp_pkg::LEN_W-1:0]             out_length,
    output logic [afdp_pkg::FQ_W-1:0]              frames_queued,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [afdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [afdp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [afdp_pkg::CH_W-1:0]  channel_count_reg;
    logic [afdp_pkg::QB_W-1:0]  baseline_bytes_reg;
    logic [afdp_pkg::LIM_W-1:0] min_frames_reg;
    logic [afdp_pkg::LIM_W-1:0] max_frames_reg;
    logic [afdp_pkg::LIM_W-1:0] hard_limit_reg;

    afdp_pkg::qstat_t       q_stat;
    afdp_pkg::frame_entry_t push_entry;
    afdp_pkg::frame_entry_t pop_entry;
    logic                   push;
    logic                   pop;

    // Configuration writes are taken every cycle; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= afdp_pkg::CH_W'(2);
            baseline_bytes_reg <= '0;
            min_frames_reg     <= afdp_pkg::LIM_W'(2);
            max_frames_reg     <= afdp_pkg::LIM_W'(4);
            hard_limit_reg     <= afdp_pkg::LIM_W'(20);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afdp_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg  <= cfg_data[afdp_pkg::CH_W-1:0];
                afdp_pkg::REG_BASELINE_BYTES:
                    baseline_bytes_reg <= cfg_data[afdp_pkg::QB_W-1:0];
                afdp_pkg::REG_MIN_FRAMES:
                    min_frames_reg     <= cfg_data[afdp_pkg::LIM_W-1:0];
                afdp_pkg::REG_MAX_FRAMES:
                    max_frames_reg     <= cfg_data[afdp_pkg::LIM_W-1:0];
                afdp_pkg::REG_HARD_LIMIT:
                    hard_limit_reg     <= cfg_data[afdp_pkg::LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end classifies each input beat.
    afdp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .queued_bytes   (queued_bytes),
        .frame_tag      (frame_tag),
        .frame_length   (frame_length),
        .channel_count  (channel_count_reg),
        .baseline_bytes (baseline_bytes_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_entry     (push_entry)
    );

    // Queue decouples the front from the back.
    afdp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    // Back end divides, applies the drop policy and holds the result beat.
    afdp_back
    #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .DROP_PERIOD   (DROP_PERIOD)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .min_frames    (min_frames_reg),
        .max_frames    (max_frames_reg),
        .hard_limit    (hard_limit_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .forward       (forward),
        .drop_kind     (drop_kind),
        .out_tag       (out_tag),
        .out_length    (out_length),
        .frames_queued (frames_queued)
    );

endmodule

`default_nettype wire

@@ hw/rtl/afdp_front.sv @@
// Front end: takes input beats, removes the baseline and normalizes the channel count.
// Depends on afdp_pkg.
`default_nettype none

module afdp_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [afdp_pkg::QB_W-1:0]        queued_bytes,
    input  wire logic [afdp_pkg::TAG_W-1:0]       frame_tag,
    input  wire logic [afdp_pkg::LEN_W-1:0]       frame_length,
    input  wire logic [afdp_pkg::CH_W-1:0]        channel_count,
    input  wire logic [afdp_pkg::QB_W-1:0]        baseline_bytes,
    input  wire afdp_pkg::qstat_t                 q_stat,
    output logic                                  push,
    output afdp_pkg::frame_entry_t                push_entry
);

    logic                   valid_reg;
    logic                   valid_next;
    afdp_pkg::frame_entry_t entry_reg;
    afdp_pkg::frame_entry_t entry_next;
    logic                   accept;
    logic [afdp_pkg::QB_W:0] diff;

    // The holding stage is stalled only while it is full and the queue cannot take it.
    assign push     = valid_reg && !q_stat.full;
    assign in_stall = valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;

    // Baseline removal floors at zero; a zero channel count counts as one.
    always_comb
    begin
        diff = {1'b0, queued_bytes} - {1'b0, baseline_bytes};
        entry_next        = entry_reg;
        valid_next        = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next        = 1'b1;
            entry_next.excess = diff[afdp_pkg::QB_W] ? '0 : diff[afdp_pkg::QB_W-1:0];
            entry_next.chan   = (channel_count == '0) ? afdp_pkg::CH_W'(1) : channel_count;
            entry_next.tag    = frame_tag;
            entry_next.length = frame_length;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_entry = entry_reg;

endmodule

`default_nettype wire

@@ hw/rtl/afdp_queue.sv @@
// Short queue of classified frames between front and back.
// Depends on afdp_pkg and the assertion macro header.
`default_nettype none
`include "audio_frame_drop_policy_macros.svh"

module afdp_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire afdp_pkg::frame_entry_t push_entry,
    input  wire logic                   pop,
    output afdp_pkg::frame_entry_t      pop_entry,
    output afdp_pkg::qstat_t            q_stat
);

    localparam int PTR_W = (afdp_pkg::QUEUE_DEPTH > 1) ? $clog2(afdp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(afdp_pkg::QUEUE_DEPTH + 1);

    afdp_pkg::frame_entry_t entries_reg [afdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign q_stat.full  = (count_reg == CNT_W'(afdp_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_entry    = entries_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(afdp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(afdp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `AFDP_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !q_stat.full, "push into full queue")
    `AFDP_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
    `AFDP_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(afdp_pkg::QUEUE_DEPTH), "queue fill count out of range")

endmodule

`default_nettype wire

@@ hw/rtl/afdp_back.sv @@
// Back end: serial divide to whole frames, drop policy update and output register.
// Depends on afdp_pkg and the assertion macro header.
`default_nettype none
`include "audio_frame_drop_policy_macros.svh"

module afdp_back
#(
    parameter int FRAME_SAMPLES = 240,
    parameter int DROP_PERIOD   = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire afdp_pkg::qstat_t              q_stat,
    input  wire afdp_pkg::frame_entry_t        pop_entry,
    output logic                               pop,
    input  wire logic [afdp_pkg::LIM_W-1:0]    min_frames,
    input  wire logic [afdp_pkg::LIM_W-1:0]    max_frames,
    input  wire logic [afdp_pkg::LIM_W-1:0]    hard_limit,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               forward,
    output logic [afdp_pkg::KIND_W-1:0]        drop_kind,
    output logic [afdp_pkg::TAG_W-1:0]         out_tag,
    output logic [afdp_pkg::LEN_W-1:0]         out_length,
    output logic [afdp_pkg::FQ_W-1:0]          frames_queued
);

    // The divisor reaches two bytes times fifteen channels per sample.
    localparam int FB_W  = $clog2(FRAME_SAMPLES * 30 + 1);
    localparam int CNT_W = $clog2(DROP_PERIOD);
    localparam int EX_W  = afdp_pkg::QB_W;
    localparam int FQ_W  = afdp_pkg::FQ_W;

    afdp_pkg::back_state_t          state_reg;
    afdp_pkg::back_state_t          state_next;
    logic [afdp_pkg::STEP_W-1:0]    step_reg;
    logic [afdp_pkg::STEP_W-1:0]    step_next;
    logic [EX_W-1:0]                dq_reg;
    logic [EX_W-1:0]                dq_next;
    logic [FB_W-1:0]                rem_reg;
    logic [FB_W-1:0]                rem_next;
    logic [FB_W-1:0]                divisor_reg;
    logic [FB_W-1:0]                divisor_next;
    logic [afdp_pkg::TAG_W-1:0]     tag_reg;
    logic [afdp_pkg::TAG_W-1:0]     tag_next;
    logic [afdp_pkg::LEN_W-1:0]     len_reg;
    logic [afdp_pkg::LEN_W-1:0]     len_next;
    logic [FQ_W-1:0]                hard_reg;
    logic [FQ_W-1:0]                hard_next;
    logic [FQ_W-1:0]                soft_reg;
    logic [FQ_W-1:0]                soft_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           forward_reg;
    logic                           forward_next;
    logic [afdp_pkg::KIND_W-1:0]    drop_kind_reg;
    logic [afdp_pkg::KIND_W-1:0]    drop_kind_next;
    logic [afdp_pkg::TAG_W-1:0]     out_tag_reg;
    logic [afdp_pkg::TAG_W-1:0]     out_tag_next;
    logic [afdp_pkg::LEN_W-1:0]     out_length_reg;
    logic [afdp_pkg::LEN_W-1:0]     out_length_next;
    logic [FQ_W-1:0]                fq_out_reg;
    logic [FQ_W-1:0]                fq_out_next;

    logic [FB_W:0]                  rem_shift;
    logic [FB_W:0]                  rem_diff;
    logic                           rem_ge;
    logic [FQ_W-1:0]                fq;
    logic [FQ_W-1:0]                min16;
    logic [FQ_W:0]                  hs_sum;
    logic [FQ_W:0]                  hs_gap;
    logic [FQ_W-1:0]                h_gap;
    logic [FQ_W-1:0]                h1;
    logic [FQ_W-1:0]                s1;
    logic [FQ_W-1:0]                h2;
    logic [FQ_W-1:0]                s2;
    logic [CNT_W-1:0]               cnt_adv;
    logic                           fwd_d;
    logic [afdp_pkg::KIND_W-1:0]    kind_d;
    logic                           load;

    // One restoring divider step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[EX_W-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_diff  = rem_shift - {1'b0, divisor_reg};
    end

    // Drop policy on the finished quotient; frames queued saturate at 16 bits.
    always_comb
    begin
        fq      = (dq_reg[EX_W-1:FQ_W] != '0) ? {FQ_W{1'b1}} : dq_reg[FQ_W-1:0];
        min16   = FQ_W'(min_frames);
        cnt_adv = (cnt_reg == CNT_W'(DROP_PERIOD - 1)) ? '0 : cnt_reg + 1'b1;
        h_gap   = fq - hard_reg;
        hs_sum  = {1'b0, hard_reg} + {1'b0, soft_reg};
        hs_gap  = {1'b0, fq} - hs_sum;
        h1      = hard_reg;
        s1      = soft_reg;
        if (fq <= min16)
        begin
            h1 = '0;
            s1 = '0;
        end
        else if ((fq > hard_reg) && (h_gap > FQ_W'(hard_limit)))
        begin
            h1 = fq - min16;
        end
        else if (({1'b0, fq} > hs_sum) && (hs_gap > (FQ_W + 1)'(max_frames)))
        begin
            s1 = fq - min16;
        end

        // Hard drops go first; a soft drop waits for the start of the period.
        h2     = h1;
        s2     = s1;
        fwd_d  = 1'b1;
        kind_d = afdp_pkg::KIND_NONE;
        if (h1 != '0)
        begin
            h2     = h1 - 1'b1;
            fwd_d  = 1'b0;
            kind_d = afdp_pkg::KIND_HARD;
        end
        else if ((s1 != '0) && (cnt_adv == '0))
        begin
            s2     = s1 - 1'b1;
            fwd_d  = 1'b0;
            kind_d = afdp_pkg::KIND_SOFT;
        end
    end

    // Sequencer: fetch, divide, decide.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        hard_next       = hard_reg;
        soft_next       = soft_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        forward_next    = forward_reg;
        drop_kind_next  = drop_kind_reg;
        out_tag_next    = out_tag_reg;
        out_length_next = out_length_reg;
        fq_out_next     = fq_out_reg;
        pop             = 1'b0;
        load            = 1'b0;

        unique case (state_reg)
            afdp_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop          = 1'b1;
                    dq_next      = pop_entry.excess;
                    rem_next     = '0;
                    divisor_next = FB_W'(FRAME_SAMPLES * 2) * FB_W'(pop_entry.chan);
                    tag_next     = pop_entry.tag;
                    len_next     = pop_entry.length;
                    step_next    = '0;
                    state_next   = afdp_pkg::ST_DIVIDE;
                end
            end
            afdp_pkg::ST_DIVIDE:
            begin
                rem_next  = rem_ge ? rem_diff[FB_W-1:0] : rem_shift[FB_W-1:0];
                dq_next   = {dq_reg[EX_W-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == afdp_pkg::STEP_W'(afdp_pkg::DIV_STEPS - 1))
                begin
                    state_next = afdp_pkg::ST_DECIDE;
                end
            end
            afdp_pkg::ST_DECIDE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load            = 1'b1;
                    hard_next       = h2;
                    soft_next       = s2;
                    cnt_next        = cnt_adv;
                    out_valid_next  = 1'b1;
                    forward_next    = fwd_d;
                    drop_kind_next  = kind_d;
                    out_tag_next    = tag_reg;
                    out_length_next = len_reg;
                    fq_out_next     = fq;
                    state_next      = afdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afdp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and policy state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= afdp_pkg::ST_IDLE;
            step_reg      <= '0;
            hard_reg      <= '0;
            soft_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            hard_reg      <= hard_next;
            soft_reg      <= soft_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge clk)
    begin
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        tag_reg        <= tag_next;
        len_reg        <= len_next;
        forward_reg    <= forward_next;
        drop_kind_reg  <= drop_kind_next;
        out_tag_reg    <= out_tag_next;
        out_length_reg <= out_length_next;
        fq_out_reg     <= fq_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign forward       = forward_reg;
    assign drop_kind     = drop_kind_reg;
    assign out_tag       = out_tag_reg;
    assign out_length    = out_length_reg;
    assign frames_queued = fq_out_reg;

    `AFDP_ASSERT_NOW(a_fwd_matches_kind, clk, rst_n, out_valid_reg,
        forward_reg == (drop_kind_reg == afdp_pkg::KIND_NONE),
        "forward flag disagrees with drop kind")
    `AFDP_ASSERT_NEXT(a_soft_at_period_start, clk, rst_n,
        load && (kind_d == afdp_pkg::KIND_SOFT), cnt_reg == '0,
        "soft drop off period start")
    `AFDP_ASSERT_NOW(a_load_only_when_free, clk, rst_n, load,
        !out_valid_reg || !out_stall, "result overwrote a waiting beat")

endmodule

`default_nettype wire
